// File: hw/rtl/addressed_frame_receiver_top_defines.svh
// Assertion macros for the addressed frame receiver checker.
// Needs nothing else; included by the checker file only.
`ifndef ADDRESSED_FRAME_RECEIVER_TOP_DEFINES_SVH
`define ADDRESSED_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afr assertion failed");

`endif

// File: hw/rtl/afr_pkg.sv
// Shared types, constants and helper functions for the addressed frame receiver.
// No dependencies; imported by every module of the block.
package afr_pkg;

    localparam int BUF_BYTES = 32;                    // frame buffer depth in bytes
    localparam logic [7:0] BUF_LIMIT = 8'(BUF_BYTES);
    localparam int CNT_W = 6;                         // width of the byte position counter

    localparam logic [7:0] CHK_XOR    = 8'hAA;
    localparam logic [2:0] LEN_TOP_BIT = 3'b100;
    localparam logic [7:0] MY_ADDR_RESET = 8'd1;

    // Result status codes
    localparam logic [1:0] ST_IN_FRAME = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // One classified item on its way to the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [4:0] pos;
        logic [1:0] status;
        logic [7:0] sum;      // checksum of the earlier bytes of the frame
    } afr_item_t;

    typedef struct packed {
        logic      push;
        afr_item_t item;
    } afr_push_t;

    // Length byte: top three bits must equal low3 xor (4 | bits 4..3)
    function automatic logic length_ok(input logic [7:0] b);
        logic [2:0] t;
        t = LEN_TOP_BIT | {1'b0, b[4:3]};
        return b[7:5] == (b[2:0] ^ t);
    endfunction

    function automatic logic [7:0] chk_term(input logic [7:0] b, input logic [7:0] pos);
        return (b + pos) ^ CHK_XOR;
    endfunction

endpackage

// File: hw/rtl/addressed_frame_receiver_top.sv
// Addressed frame receiver: top level.
// Takes 9-bit received symbols (rx_byte plus address_mark) on the input channel
// and streams out the bytes of frames addressed to this station, each with its
// position, a status code and, on the last byte, a checksum verdict.
// Input channel: in_valid / in_stall; an item is taken at a clock edge with
// in_valid high and in_stall low. Output channel: out_valid / out_stall, same rule.
// Configuration: cfg_wr_en writes cfg_wr_data into the station address
// (reset value 1) at the clock edge; write it only while the block is idle.
// Throughput: one item per cycle sustained while in_stall stays low; every
// offered symbol is taken, and dropped symbols (outside a frame) produce no result.
// An item taken at a clock edge passes through a queue entry, then the output
// register, before its result shows on out_valid.
// When out_stall is held, the output holds its item, the two-entry queue fills,
// and in_stall rises once the queue is full; it falls as soon as one entry drains.
// Reset (rst_n low, asynchronous) empties the queue and the output, sets the
// station address to 1 and puts the receiver back to waiting for an address.
// Depends on afr_pkg, afr_front, afr_queue and afr_back.
module addressed_frame_receiver_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       address_mark,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_out,
    output logic [4:0] position,
    output logic [1:0] status,
    output logic       checksum_ok
);
    import afr_pkg::*;

    afr_push_t front_push;
    afr_item_t q_head;
    logic      q_full;
    logic      q_not_empty;
    logic      back_pop;

    // Stall the sender only when the queue has no room left.
    assign in_stall = q_full;

    // Front: filter by address, track the frame and classify each item.
    afr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (q_full),
        .rx_byte      (rx_byte),
        .address_mark (address_mark),
        .push_out     (front_push)
    );

    // Hold classified items while the output side stalls.
    afr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_in   (front_push),
        .pop       (back_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Back: settle the checksum verdict and present the result item.
    afr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (q_not_empty),
        .head        (q_head),
        .pop         (back_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .byte_out    (byte_out),
        .position    (position),
        .status      (status),
        .checksum_ok (checksum_ok)
    );

endmodule

// File: hw/rtl/afr_front.sv
// Front end: address filter, frame state and classification of each item.
// Depends on afr_pkg; feeds afr_queue.
module afr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  logic              address_mark,
    output afr_pkg::afr_push_t push_out
);
    import afr_pkg::*;

    logic [7:0]       my_address_reg;
    logic             address_mode_reg, address_mode_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]       length_code_reg, length_code_next;
    logic [7:0]       running_sum_reg, running_sum_next;

    logic       accept;
    logic [7:0] length_now;
    logic [7:0] count8;
    logic [7:0] pos8;
    logic [7:0] pos_p1;

    assign accept = in_valid && !in_stall;
    assign pos8   = 8'(byte_count_reg);
    assign pos_p1 = pos8 + 8'd1;

    always_comb
    begin
        length_now = (byte_count_reg == CNT_W'(1)) ? rx_byte : length_code_reg;
        count8     = {3'b000, length_now[4:0]};
        if (count8 > BUF_LIMIT)
        begin
            count8 = BUF_LIMIT;
        end
    end

    always_comb
    begin
        address_mode_next = address_mode_reg;
        byte_count_next   = byte_count_reg;
        length_code_next  = length_code_reg;
        running_sum_next  = running_sum_reg;
        push_out.push        = 1'b0;
        push_out.item.data   = rx_byte;
        push_out.item.pos    = byte_count_reg[4:0];
        push_out.item.status = ST_IN_FRAME;
        push_out.item.sum    = running_sum_reg;

        if (accept)
        begin
            if (address_mode_reg)
            begin
                // drop everything but a marked byte carrying our address
                if (address_mark && rx_byte == my_address_reg)
                begin
                    address_mode_next  = 1'b0;
                    byte_count_next    = CNT_W'(1);
                    running_sum_next   = chk_term(rx_byte, 8'd0);
                    push_out.push      = 1'b1;
                    push_out.item.pos  = 5'd0;
                end
            end
            else if (pos8 >= BUF_LIMIT)
            begin
                address_mode_next    = 1'b1;
                push_out.push        = 1'b1;
                push_out.item.status = ST_OVERFLOW;
            end
            else
            begin
                length_code_next = length_now;
                byte_count_next  = byte_count_reg + CNT_W'(1);
                push_out.push    = 1'b1;
                if (!length_ok(length_now))
                begin
                    address_mode_next    = 1'b1;
                    push_out.item.status = ST_BAD_LEN;
                end
                else if (pos_p1 >= count8)
                begin
                    address_mode_next    = 1'b1;
                    push_out.item.status = ST_COMPLETE;
                end
                else
                begin
                    running_sum_next = running_sum_reg + chk_term(rx_byte, pos8);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_address_reg   <= MY_ADDR_RESET;
            address_mode_reg <= 1'b1;
            byte_count_reg   <= '0;
            length_code_reg  <= '0;
            running_sum_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                my_address_reg <= cfg_wr_data;
            end
            address_mode_reg <= address_mode_next;
            byte_count_reg   <= byte_count_next;
            length_code_reg  <= length_code_next;
            running_sum_reg  <= running_sum_next;
        end
    end

endmodule

// File: hw/rtl/afr_queue.sv
// Short queue between the front end and the output stage.
// Depends on afr_pkg; fed by afr_front, drained by afr_back.
module afr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  afr_pkg::afr_push_t push_in,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output afr_pkg::afr_item_t head
);
    import afr_pkg::*;

    afr_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push_in.push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_in.item;
        end
    end

endmodule

// File: hw/rtl/afr_back.sv
// Output stage: checksum compare and the registered result item.
// Depends on afr_pkg; drains afr_queue.
module afr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               not_empty,
    input  afr_pkg::afr_item_t head,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [7:0]         byte_out,
    output logic [4:0]         position,
    output logic [1:0]         status,
    output logic               checksum_ok
);
    import afr_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_out_reg;
    logic [4:0] position_reg;
    logic [1:0] status_reg;
    logic       checksum_ok_reg, checksum_ok_next;

    // advance when the output register is empty or being taken
    assign pop = not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        checksum_ok_next = (head.status == ST_COMPLETE) && (head.data == head.sum);
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_out_reg    <= head.data;
            position_reg    <= head.pos;
            status_reg      <= head.status;
            checksum_ok_reg <= checksum_ok_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_out    = byte_out_reg;
    assign position    = position_reg;
    assign status      = status_reg;
    assign checksum_ok = checksum_ok_reg;

endmodule

// File: hw/rtl/afr_checker.sv
// Port-level checks for the addressed frame receiver, bound to the top level.
// Depends on afr_pkg and addressed_frame_receiver_top_defines.svh.
`include "addressed_frame_receiver_top_defines.svh"

module afr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] byte_out,
    input logic [4:0] position,
    input logic [1:0] status,
    input logic       checksum_ok
);
    import afr_pkg::*;

    // A stalled result item holds.
    `AFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(byte_out) && $stable(position) && $stable(status) && $stable(checksum_ok))

    // The checksum verdict is only ever set on a completed frame.
    `AFR_ASSERT_NOW(a_chk_only_complete, clk, rst_n, out_valid && (status != ST_COMPLETE),
        !checksum_ok)

    // The address byte at position zero always opens a frame.
    `AFR_ASSERT_NOW(a_addr_in_frame, clk, rst_n, out_valid && (position == 5'd0),
        status == ST_IN_FRAME)

    // A bad length code can only be reported on the length byte.
    `AFR_ASSERT_NOW(a_bad_len_pos, clk, rst_n, out_valid && (status == ST_BAD_LEN),
        position == 5'd1)

endmodule

bind addressed_frame_receiver_top afr_checker u_afr_checker (.*);
